FILE: sv/dfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfp_pkg
// Shared types, constants and helpers for the decimal to fixed-point parser.
// ---------------------------------------------------------------------------
package dfp_pkg;

  localparam int MAX_CHARS_DEF = 15;

  localparam int INT_W  = 12;  // integer magnitude, saturates at INT_LIMIT+1
  localparam int FRAC_W = 20;  // fraction in micro-units, up to 999999
  localparam int PROD_W = 32;  // integer part times SCALE
  localparam int VAL_W  = 33;

  localparam logic [INT_W-1:0]  INT_LIMIT   = INT_W'(2147);
  localparam logic [2:0]        FRAC_DIGITS = 3'd6;
  localparam logic [PROD_W-1:0] SCALE       = PROD_W'(1000000);
  localparam logic [VAL_W-1:0]  POS_LIMIT   = 33'h0_7FFF_FFFF;
  localparam logic [VAL_W-1:0]  NEG_LIMIT   = 33'h0_8000_0000;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_CONV = 2'd2
  } status_t;

  // Parse state gathered over the characters of one number.
  typedef struct packed {
    logic              negative;
    logic              plus_sign;
    logic              int_seen;
    logic [INT_W-1:0]  int_accum;
    logic              point_seen;
    logic [FRAC_W-1:0] frac_accum;  // already scaled to micro-units
    logic [2:0]        frac_count;
    logic              bad_char;
  } scan_t;

  // Weight of the fraction digit at position pos (0 = first after point).
  function automatic logic [16:0] frac_weight(input logic [2:0] pos);
    logic [16:0] w;
    case (pos)
      3'd0:    w = 17'd100000;
      3'd1:    w = 17'd10000;
      3'd2:    w = 17'd1000;
      3'd3:    w = 17'd100;
      3'd4:    w = 17'd10;
      3'd5:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/dfp_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfp_scan
// Per-character parse state: sign, integer and fraction accumulators, count.
// ---------------------------------------------------------------------------
module dfp_scan #(
  parameter int MAX_CHARS = dfp_pkg::MAX_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,     // a character item accepted
  input  logic           clear,    // an end item accepted
  input  logic [7:0]     ch,
  output logic           len_err,
  output dfp_pkg::scan_t scan
);

  localparam int CNT_W = $clog2(MAX_CHARS + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

  logic [CNT_W-1:0] char_count, char_count_next;
  dfp_pkg::scan_t   scan_next;

  logic                      is_digit;
  logic [3:0]                digit;
  logic [14:0]               int_mul;
  logic [dfp_pkg::FRAC_W-1:0] frac_add;

  assign len_err  = (char_count == '0) || (char_count > CNT_MAX);
  assign is_digit = (ch >= dfp_pkg::CH_ZERO) && (ch <= dfp_pkg::CH_NINE);
  assign digit    = 4'(ch - dfp_pkg::CH_ZERO);
  assign int_mul  = (15'(scan.int_accum) << 3) + (15'(scan.int_accum) << 1) + 15'(digit);
  assign frac_add = dfp_pkg::FRAC_W'(digit) *
                    dfp_pkg::FRAC_W'(dfp_pkg::frac_weight(scan.frac_count));

  always_comb begin
    char_count_next = char_count;
    scan_next       = scan;
    if (clear) begin
      char_count_next = '0;
      scan_next       = '0;
    end else if (take && (char_count <= CNT_MAX)) begin
      char_count_next = char_count + 1'b1;
      // last counted position is only counted, not parsed
      if (char_count < CNT_MAX) begin
        if ((ch == dfp_pkg::CH_MINUS) || (ch == dfp_pkg::CH_PLUS)) begin
          if (char_count == '0) begin
            if (ch == dfp_pkg::CH_MINUS) scan_next.negative = 1'b1;
            else scan_next.plus_sign = 1'b1;
          end else begin
            scan_next.bad_char = 1'b1;
          end
        end else if (is_digit) begin
          if (scan.point_seen) begin
            if (scan.frac_count < dfp_pkg::FRAC_DIGITS) begin
              scan_next.frac_accum = scan.frac_accum + frac_add;
              scan_next.frac_count = scan.frac_count + 3'd1;
            end
          end else begin
            scan_next.int_seen  = 1'b1;
            scan_next.int_accum = (int_mul > 15'(dfp_pkg::INT_LIMIT)) ?
                                  dfp_pkg::INT_LIMIT + 1'b1 : dfp_pkg::INT_W'(int_mul);
          end
        end else if (ch == dfp_pkg::CH_POINT) begin
          if (scan.point_seen) scan_next.bad_char = 1'b1;
          else scan_next.point_seen = 1'b1;
        end else begin
          scan_next.bad_char = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      scan       <= '0;
    end else begin
      char_count <= char_count_next;
      scan       <= scan_next;
    end
  end

endmodule

FILE: sv/decimal_to_fixed_point_parse.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_to_fixed_point_parse
// Decimal string to signed micro-unit fixed point, with a status code.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): one item per character in ch, or
//   an end item (end_req=1, ch ignored) that closes the number.
//   Response channel (rsp_valid/rsp_ready): one item per end item, carrying
//   value (number * 1e6, signed 33 bits, 0 unless ok) and status
//   (ok / length error / conversion error). Character items give no response.
// Timing:
//   Characters are folded into the parse state in the cycle they are taken,
//   one per cycle while req_ready is high. An end item goes through two
//   registers: the first holds the checks and the integer part times 1e6 (the
//   constant multiply), the second the fraction add, range compare and negate.
//   rsp_valid rises once the result moves from the finish register into the
//   output register. Throughput is one item per cycle while req_ready is high.
// Stall:
//   When the response is held, the finish register still drains into the
//   output register if that frees; req_ready drops only once the finish
//   register is full and cannot move on.
// Reset:
//   rst clears the parse state and both valid flags; no response is pending.
// ---------------------------------------------------------------------------
module decimal_to_fixed_point_parse #(
  parameter int MAX_CHARS = dfp_pkg::MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [7:0]  ch,
  input  logic        end_req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic signed [32:0] value,
  output logic [1:0]  status
);

  // handshake
  logic req_fire, char_take, end_take;
  logic s1_valid, s1_load, s2_load, s1_free;

  // parse state
  logic           len_err;
  dfp_pkg::scan_t scan;
  logic           conv_err;

  // finish register
  dfp_pkg::status_t             s1_status;
  logic [dfp_pkg::PROD_W-1:0]   s1_prod;
  logic [dfp_pkg::FRAC_W-1:0]   s1_frac;
  logic                         s1_neg;

  // output stage logic
  logic [dfp_pkg::VAL_W-1:0]    mag;
  logic                         over;
  dfp_pkg::status_t             out_status;
  logic [dfp_pkg::VAL_W-1:0]    out_value;

  assign s2_load   = s1_valid && (!rsp_valid || rsp_ready);
  assign s1_free   = !s1_valid || s2_load;
  assign req_ready = s1_free;
  assign req_fire  = req_valid && req_ready;
  assign char_take = req_fire && !end_req;
  assign end_take  = req_fire && end_req;
  assign s1_load   = end_take;

  dfp_scan #(
    .MAX_CHARS(MAX_CHARS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .take   (char_take),
    .clear  (end_take),
    .ch     (ch),
    .len_err(len_err),
    .scan   (scan)
  );

  // form errors; length error takes precedence
  assign conv_err = scan.bad_char ||
                    (!scan.int_seen && (!scan.point_seen || scan.plus_sign)) ||
                    (scan.int_accum > dfp_pkg::INT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_status <= len_err ? dfp_pkg::ST_LEN : (conv_err ? dfp_pkg::ST_CONV : dfp_pkg::ST_OK);
      s1_prod   <= dfp_pkg::PROD_W'(scan.int_accum) * dfp_pkg::SCALE;
      s1_frac   <= scan.frac_accum;
      s1_neg    <= scan.negative;
    end
  end

  // add fraction, range check against signed 32-bit, apply sign
  assign mag  = dfp_pkg::VAL_W'(s1_prod) + dfp_pkg::VAL_W'(s1_frac);
  assign over = s1_neg ? (mag > dfp_pkg::NEG_LIMIT) : (mag > dfp_pkg::POS_LIMIT);

  always_comb begin
    out_status = s1_status;
    out_value  = '0;
    if (s1_status == dfp_pkg::ST_OK) begin
      if (over) begin
        out_status = dfp_pkg::ST_CONV;
      end else begin
        out_value = s1_neg ? (~mag + 1'b1) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      value  <= $signed(out_value);
      status <= out_status;
    end
  end

  // ---- checks ----
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != dfp_pkg::ST_OK) |-> (value == '0))
    else $error("nonzero value with error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == dfp_pkg::ST_OK) || (status == dfp_pkg::ST_LEN) ||
                  (status == dfp_pkg::ST_CONV))
    else $error("undefined status code");

  a_end_lands: assert property (@(posedge clk) disable iff (rst)
    end_take |=> s1_valid)
    else $error("end item lost before finish register");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid && $stable(s1_prod) && $stable(s1_frac))
    else $error("finish register changed while stalled");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> rsp_valid)
    else $error("result dropped into output register");

endmodule
